/* rtl/core/macd_indicator_stream_assert.svh */
// Assertion macros for the MACD indicator stream block.
// Used by macd_checker, the only file that includes it; no other dependencies.
`ifndef MACD_INDICATOR_STREAM_ASSERT_SVH
`define MACD_INDICATOR_STREAM_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define MACD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define MACD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/macd_pkg.sv */
// Shared types, widths and constants of the MACD indicator stream block.
// No dependencies; used by the other RTL modules and interfaces by scoped names.
`default_nettype none

package macd_pkg;

	localparam int PRICE_W    = 32;
	localparam int SPAN_W     = 10;
	localparam int OUT_W      = 40;
	localparam int NUM_W      = 64;
	localparam int DEN_W      = 48;
	localparam int DEC_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam int MEANS      = 3;

	// register indexes, also the slot of each mean in the sum arrays
	localparam logic [CFG_IDX_W-1:0] CFG_FAST   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOW   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNAL = 2'd2;

	localparam logic [SPAN_W-1:0] FAST_SPAN_RST   = 10'd12;
	localparam logic [SPAN_W-1:0] SLOW_SPAN_RST   = 10'd26;
	localparam logic [SPAN_W-1:0] SIGNAL_SPAN_RST = 10'd9;

	// floor((s-1) * 2^32 / (s+1)) for the reset spans
	localparam logic [DEC_W-1:0] FAST_DEC_RST   = 32'd3634203096;
	localparam logic [DEC_W-1:0] SLOW_DEC_RST   = 32'd3976821570;
	localparam logic [DEC_W-1:0] SIGNAL_DEC_RST = 32'd3435973836;

	localparam logic [DEN_W-1:0] ONE_Q32 = 48'h0001_0000_0000;

	// multiply sequence: numerator low/high half, denominator low/high half, then a sum step
	localparam logic [2:0] MUL_N_LO = 3'd0;
	localparam logic [2:0] MUL_N_HI = 3'd1;
	localparam logic [2:0] MUL_D_LO = 3'd2;
	localparam logic [2:0] MUL_D_HI = 3'd3;
	localparam logic [2:0] MUL_SUM  = 3'd4;

	// divider retires two quotient bits per cycle
	localparam logic [4:0] DIV_LAST = 5'd31;

	typedef struct packed {
		logic                 load;
		logic                 mul_en;
		logic [2:0]           mul_step;
		logic                 sig_phase;
		logic                 upd;
		logic                 div_start;
		logic                 dec_start;
		logic [CFG_IDX_W-1:0] dec_idx;
		logic                 dec_wr;
		logic                 macd_ld;
		logic                 out_ld;
	} macd_cmd_t;

	typedef struct packed {
		logic [MEANS-1:0] dirty;
		logic             div_done;
		logic             out_busy;
	} macd_stat_t;

	// clamp a 65-bit two's complement value to the signed 40-bit range
	function automatic logic [OUT_W-1:0] sat_out(input logic [NUM_W:0] v);
		logic [OUT_W-1:0] r;
		if (!v[NUM_W] && (v[NUM_W-1:OUT_W-1] != '0)) begin
			r = {1'b0, {(OUT_W-1){1'b1}}};
		end else if (v[NUM_W] && (v[NUM_W-1:OUT_W-1] != '1)) begin
			r = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = v[OUT_W-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/macd_stream_if.sv */
// Stream channels of the MACD block: price items in, indicator items out.
// Depends on macd_pkg for field widths.
`default_nettype none

interface macd_price_if;
	logic                               valid;
	logic                               ready;
	logic [macd_pkg::PRICE_W-1:0]       close_price;
	logic                               restart;
	modport source (output valid, close_price, restart, input ready);
	modport sink (input valid, close_price, restart, output ready);
endinterface

interface macd_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [macd_pkg::OUT_W-1:0]  macd_value;
	logic signed [macd_pkg::OUT_W-1:0]  signal_value;
	logic signed [macd_pkg::OUT_W-1:0]  histogram;
	modport source (output valid, macd_value, signal_value, histogram, input ready);
	modport sink (input valid, macd_value, signal_value, histogram, output ready);
endinterface

`default_nettype wire

/* rtl/core/macd_indicator_stream.sv */
// MACD indicator over a stream of Q16.16 closing prices. Each item runs
// two passes (a multiply sequence, a sum update, a divider start and a wait
// on the radix-4 divider; fast and slow means divide side by side, then the
// signal mean), a step between them for the MACD line and a last step that
// loads the output register, waiting while the previous result is untaken. The
// next item can be accepted in the cycle after a result is loaded into the output
// register, even while that result still waits to be taken, unless a span
// write is pending. A span write holds off input items while the new decay is
// divided out. Top level: joins macd_ctrl and macd_dp; depends on macd_pkg
// and the stream interfaces.
`default_nettype none

module macd_indicator_stream (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	macd_price_if.sink                           price_ch,
	macd_result_if.source                        result_ch,
	input  wire logic                            cfg_we,
	input  wire logic [macd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [macd_pkg::CFG_DATA_W-1:0] cfg_data
);

	macd_pkg::macd_cmd_t  cmd;
	macd_pkg::macd_stat_t stat;
	logic                 in_ready;
	logic                 out_valid;
	logic [macd_pkg::OUT_W-1:0] macd_v, sig_v, hist_v;

	macd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (price_ch.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	macd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.close_price  (price_ch.close_price),
		.restart      (price_ch.restart),
		.out_valid    (out_valid),
		.out_ready    (result_ch.ready),
		.macd_value   (macd_v),
		.signal_value (sig_v),
		.histogram    (hist_v)
	);

	assign price_ch.ready         = in_ready;
	assign result_ch.valid        = out_valid;
	assign result_ch.macd_value   = macd_v;
	assign result_ch.signal_value = sig_v;
	assign result_ch.histogram    = hist_v;

endmodule

`default_nettype wire

/* rtl/core/macd_div.sv */
// Radix-4 restoring divider: (dividend << 32) / divisor, 64-bit quotient.
// Needs dividend[63:32] < divisor. Uses macd_pkg widths.
`default_nettype none

module macd_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [macd_pkg::NUM_W-1:0]    dividend,
	input  wire logic [macd_pkg::DEN_W-1:0]    divisor,
	output logic                               done,
	output logic [macd_pkg::NUM_W-1:0]         quotient
);

	localparam int NW = macd_pkg::NUM_W;
	localparam int DW = macd_pkg::DEN_W;

	logic          busy_q;
	logic          done_q;
	logic [4:0]    cnt_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] div_q;
	logic [NW-1:0] sh_q;
	logic [NW-1:0] quo_q;

	logic [DW:0]   t1, t2;
	logic [DW-1:0] r1, r2;
	logic          b1, b0;

	always_comb begin
		t1 = {rem_q, sh_q[NW-1]};
		b1 = (t1 >= {1'b0, div_q});
		r1 = b1 ? DW'(t1 - {1'b0, div_q}) : t1[DW-1:0];
		t2 = {r1, sh_q[NW-2]};
		b0 = (t2 >= {1'b0, div_q});
		r2 = b0 ? DW'(t2 - {1'b0, div_q}) : t2[DW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == macd_pkg::DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == macd_pkg::DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {{(DW-NW/2){1'b0}}, dividend[NW-1:NW/2]};
			sh_q  <= {dividend[NW/2-1:0], {(NW/2){1'b0}}};
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= r2;
			sh_q  <= {sh_q[NW-3:0], 2'b00};
			quo_q <= {quo_q[NW-3:0], b1, b0};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* rtl/core/macd_dp.sv */
// Datapath of the MACD block: spans, decays, sums, two multiply lanes,
// two dividers and the output register. Uses macd_pkg and macd_div.
`default_nettype none

module macd_dp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire macd_pkg::macd_cmd_t                 cmd,
	output macd_pkg::macd_stat_t                     stat,
	input  wire logic                                cfg_we,
	input  wire logic [macd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [macd_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic [macd_pkg::PRICE_W-1:0]        close_price,
	input  wire logic                                restart,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [macd_pkg::OUT_W-1:0]               macd_value,
	output logic [macd_pkg::OUT_W-1:0]               signal_value,
	output logic [macd_pkg::OUT_W-1:0]               histogram
);

	localparam int NW = macd_pkg::NUM_W;
	localparam int DW = macd_pkg::DEN_W;
	localparam int KW = macd_pkg::DEC_W;
	localparam int OW = macd_pkg::OUT_W;
	localparam int SW = macd_pkg::SPAN_W;
	localparam int PW = macd_pkg::PRICE_W;
	localparam int M  = macd_pkg::MEANS;

	logic [SW-1:0] span_q  [M];
	logic [KW-1:0] dec_q   [M];
	logic [NW-1:0] num_q   [M];
	logic [DW-1:0] den_q   [M];
	logic [M-1:0]  dirty_q;
	logic [PW-1:0] price_q;
	logic [OW-1:0] macd_q;

	logic [NW-1:0] prod_a_q, prod_b_q;
	logic [NW-1:0] accn_a_q, accn_b_q;
	logic [DW-1:0] accd_a_q, accd_b_q;
	logic          neg_a_q, neg_b_q;

	logic          out_valid_q;
	logic [OW-1:0] macd_out_q, sig_out_q, hist_out_q;

	// lane A serves the fast mean, then the signal mean; lane B the slow mean
	logic [NW-1:0] num_a, num_b, mag_a, mag_b, v_a, v_b, new_num_a, new_num_b;
	logic [DW-1:0] den_a, den_b;
	logic [KW-1:0] dec_a, dec_b;
	logic [KW-1:0] op_a, op_b;
	logic [SW-1:0] span_sel, span_eff;
	logic [NW-1:0] div_a_num;
	logic [DW-1:0] div_a_den;
	logic          div_a_start, div_b_start, done_a, done_b;
	logic [NW-1:0] quo_a, quo_b, q_a, q_b;
	logic [OW-1:0] sig_val;

	always_comb begin
		num_a = cmd.sig_phase ? num_q[macd_pkg::CFG_SIGNAL] : num_q[macd_pkg::CFG_FAST];
		den_a = cmd.sig_phase ? den_q[macd_pkg::CFG_SIGNAL] : den_q[macd_pkg::CFG_FAST];
		dec_a = cmd.sig_phase ? dec_q[macd_pkg::CFG_SIGNAL] : dec_q[macd_pkg::CFG_FAST];
		num_b = num_q[macd_pkg::CFG_SLOW];
		den_b = den_q[macd_pkg::CFG_SLOW];
		dec_b = dec_q[macd_pkg::CFG_SLOW];
		mag_a = num_a[NW-1] ? NW'(-num_a) : num_a;
		mag_b = num_b[NW-1] ? NW'(-num_b) : num_b;

		case (cmd.mul_step)
			macd_pkg::MUL_N_LO: begin
				op_a = mag_a[KW-1:0];
				op_b = mag_b[KW-1:0];
			end
			macd_pkg::MUL_N_HI: begin
				op_a = mag_a[NW-1:KW];
				op_b = mag_b[NW-1:KW];
			end
			macd_pkg::MUL_D_LO: begin
				op_a = den_a[KW-1:0];
				op_b = den_b[KW-1:0];
			end
			macd_pkg::MUL_D_HI: begin
				op_a = {{(2*KW-DW){1'b0}}, den_a[DW-1:KW]};
				op_b = {{(2*KW-DW){1'b0}}, den_b[DW-1:KW]};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase

		v_a = cmd.sig_phase ? {{(NW-OW){macd_q[OW-1]}}, macd_q} : {{(NW-PW){1'b0}}, price_q};
		v_b = {{(NW-PW){1'b0}}, price_q};
		new_num_a = v_a + (num_a[NW-1] ? NW'(-accn_a_q) : accn_a_q);
		new_num_b = v_b + (num_b[NW-1] ? NW'(-accn_b_q) : accn_b_q);

		// span zero behaves as span one
		span_sel  = span_q[cmd.dec_idx];
		span_eff  = (span_sel == '0) ? SW'(1) : span_sel;
		div_a_num = cmd.dec_start ? {{(NW-SW){1'b0}}, SW'(span_eff - SW'(1))}
		                          : mag_a;
		div_a_den = cmd.dec_start ? {{(DW-SW-1){1'b0}}, {1'b0, span_eff} + (SW+1)'(1)}
		                          : den_a;
		div_a_start = cmd.div_start || cmd.dec_start;
		div_b_start = cmd.div_start && !cmd.sig_phase;
	end

	macd_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_a_start),
		.dividend (div_a_num),
		.divisor  (div_a_den),
		.done     (done_a),
		.quotient (quo_a)
	);

	macd_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_b_start),
		.dividend (mag_b),
		.divisor  (den_b),
		.done     (done_b),
		.quotient (quo_b)
	);

	assign q_a = neg_a_q ? NW'(-quo_a) : quo_a;
	assign q_b = neg_b_q ? NW'(-quo_b) : quo_b;
	assign sig_val = macd_pkg::sat_out({q_a[NW-1], q_a});

	// configuration, decays and running sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q[macd_pkg::CFG_FAST]   <= macd_pkg::FAST_SPAN_RST;
			span_q[macd_pkg::CFG_SLOW]   <= macd_pkg::SLOW_SPAN_RST;
			span_q[macd_pkg::CFG_SIGNAL] <= macd_pkg::SIGNAL_SPAN_RST;
			dec_q[macd_pkg::CFG_FAST]    <= macd_pkg::FAST_DEC_RST;
			dec_q[macd_pkg::CFG_SLOW]    <= macd_pkg::SLOW_DEC_RST;
			dec_q[macd_pkg::CFG_SIGNAL]  <= macd_pkg::SIGNAL_DEC_RST;
			dirty_q <= '0;
			for (int i = 0; i < M; i++) begin
				num_q[i] <= '0;
				den_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < M; i++) begin
				if (cfg_we && (cfg_index == macd_pkg::CFG_IDX_W'(i))) begin
					span_q[i]  <= cfg_data;
					dirty_q[i] <= 1'b1;
				end else if (cmd.dec_start && (cmd.dec_idx == macd_pkg::CFG_IDX_W'(i))) begin
					dirty_q[i] <= 1'b0;
				end
			end
			if (cmd.dec_wr) begin
				dec_q[cmd.dec_idx] <= quo_a[KW-1:0];
			end
			if (cmd.load && restart) begin
				for (int i = 0; i < M; i++) begin
					num_q[i] <= '0;
					den_q[i] <= '0;
				end
			end
			if (cmd.upd) begin
				if (cmd.sig_phase) begin
					num_q[macd_pkg::CFG_SIGNAL] <= new_num_a;
					den_q[macd_pkg::CFG_SIGNAL] <= macd_pkg::ONE_Q32 + accd_a_q;
				end else begin
					num_q[macd_pkg::CFG_FAST] <= new_num_a;
					den_q[macd_pkg::CFG_FAST] <= macd_pkg::ONE_Q32 + accd_a_q;
					num_q[macd_pkg::CFG_SLOW] <= new_num_b;
					den_q[macd_pkg::CFG_SLOW] <= macd_pkg::ONE_Q32 + accd_b_q;
				end
			end
		end
	end

	// multiply lanes and intermediate values
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= close_price;
		end
		if (cmd.mul_en) begin
			prod_a_q <= op_a * dec_a;
			prod_b_q <= op_b * dec_b;
			case (cmd.mul_step)
				macd_pkg::MUL_N_HI: begin
					accn_a_q <= {{KW{1'b0}}, prod_a_q[NW-1:KW]};
					accn_b_q <= {{KW{1'b0}}, prod_b_q[NW-1:KW]};
				end
				macd_pkg::MUL_D_LO: begin
					accn_a_q <= accn_a_q + prod_a_q;
					accn_b_q <= accn_b_q + prod_b_q;
				end
				macd_pkg::MUL_D_HI: begin
					accd_a_q <= {{(DW-KW){1'b0}}, prod_a_q[NW-1:KW]};
					accd_b_q <= {{(DW-KW){1'b0}}, prod_b_q[NW-1:KW]};
				end
				macd_pkg::MUL_SUM: begin
					accd_a_q <= accd_a_q + prod_a_q[DW-1:0];
					accd_b_q <= accd_b_q + prod_b_q[DW-1:0];
				end
				default: begin
				end
			endcase
		end
		if (cmd.div_start) begin
			neg_a_q <= num_a[NW-1];
			neg_b_q <= num_b[NW-1];
		end
		if (cmd.macd_ld) begin
			macd_q <= macd_pkg::sat_out({q_a[NW-1], q_a} - {q_b[NW-1], q_b});
		end
		if (cmd.out_ld) begin
			macd_out_q <= macd_q;
			sig_out_q  <= sig_val;
			hist_out_q <= macd_pkg::sat_out({{(NW-OW+1){macd_q[OW-1]}}, macd_q}
			                                - {{(NW-OW+1){sig_val[OW-1]}}, sig_val});
		end
	end

	// result register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign stat.dirty    = dirty_q;
	assign stat.div_done = done_a && (cmd.sig_phase || done_b);
	assign stat.out_busy = out_valid_q && !out_ready;

	assign out_valid    = out_valid_q;
	assign macd_value   = macd_out_q;
	assign signal_value = sig_out_q;
	assign histogram    = hist_out_q;

endmodule

`default_nettype wire

/* rtl/core/macd_ctrl.sv */
// Controller of the MACD block: sequences decay updates and the two passes
// of each item (fast and slow means, then the signal mean). Uses macd_pkg.
`default_nettype none

module macd_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire macd_pkg::macd_stat_t stat,
	output macd_pkg::macd_cmd_t       cmd
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_DEC_RUN   = 8'b0000_0010,
		ST_MUL       = 8'b0000_0100,
		ST_UPD       = 8'b0000_1000,
		ST_DIV_START = 8'b0001_0000,
		ST_DIV_WAIT  = 8'b0010_0000,
		ST_MACD      = 8'b0100_0000,
		ST_OUT       = 8'b1000_0000
	} state_t;

	state_t                              state_q, state_d;
	logic [2:0]                          step_q;
	logic                                sig_q;
	logic [macd_pkg::CFG_IDX_W-1:0]      dec_idx_q;
	logic [macd_pkg::CFG_IDX_W-1:0]      pick;

	always_comb begin
		if (stat.dirty[macd_pkg::CFG_FAST]) begin
			pick = macd_pkg::CFG_FAST;
		end else if (stat.dirty[macd_pkg::CFG_SLOW]) begin
			pick = macd_pkg::CFG_SLOW;
		end else begin
			pick = macd_pkg::CFG_SIGNAL;
		end
	end

	assign in_ready = (state_q == ST_IDLE) && (stat.dirty == '0);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_step  = step_q;
		cmd.sig_phase = sig_q;
		cmd.dec_idx   = (state_q == ST_IDLE) ? pick : dec_idx_q;
		case (state_q)
			ST_IDLE: begin
				if (stat.dirty != '0) begin
					cmd.dec_start = 1'b1;
					state_d = ST_DEC_RUN;
				end else if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_MUL;
				end
			end
			ST_DEC_RUN: begin
				// only lane A divides a decay: wait on its divider alone
				cmd.sig_phase = 1'b1;
				if (stat.div_done) begin
					cmd.dec_wr = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				if (step_q == macd_pkg::MUL_SUM) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_DIV_START;
			end
			ST_DIV_START: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (stat.div_done) begin
					state_d = sig_q ? ST_OUT : ST_MACD;
				end
			end
			ST_MACD: begin
				cmd.macd_ld = 1'b1;
				state_d = ST_MUL;
			end
			ST_OUT: begin
				// hold while the previous result is still waiting
				if (!stat.out_busy) begin
					cmd.out_ld = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= '0;
			sig_q     <= 1'b0;
			dec_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.dec_start) begin
				dec_idx_q <= pick;
			end
			if (cmd.load) begin
				sig_q <= 1'b0;
			end else if (cmd.macd_ld) begin
				sig_q <= 1'b1;
			end
			if (cmd.mul_en) begin
				step_q <= (step_q == macd_pkg::MUL_SUM) ? '0 : step_q + 3'd1;
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/core/macd_checker.sv */
// Port-level checks of the MACD block, bound to its top level.
// Depends on macd_pkg and macd_indicator_stream_assert.svh.
`default_nettype none

`include "macd_indicator_stream_assert.svh"

module macd_checker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic                           in_ready,
	input  wire logic                           out_valid,
	input  wire logic                           out_ready,
	input  wire logic [macd_pkg::OUT_W-1:0]     macd_value,
	input  wire logic                           cfg_we,
	input  wire logic [macd_pkg::CFG_IDX_W-1:0] cfg_index
);

	`MACD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped before taken")
	`MACD_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while busy")
	`MACD_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(macd_value), "result changed")
	`MACD_ASSERT_NEXT(a_cfg_block, cfg_we && (cfg_index <= macd_pkg::CFG_SIGNAL), !in_ready,
		"item taken before decay update")

endmodule

bind macd_indicator_stream macd_checker u_macd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (price_ch.valid),
	.in_ready   (price_ch.ready),
	.out_valid  (result_ch.valid),
	.out_ready  (result_ch.ready),
	.macd_value (result_ch.macd_value),
	.cfg_we     (cfg_we),
	.cfg_index  (cfg_index)
);

`default_nettype wire

/* sim/macd_indicator_stream_test.sv */
// Self-checking testbench for macd_indicator_stream: random and directed price items,
// predicted MACD, signal and histogram items compared in order.
// Depends on macd_pkg, the stream interfaces and the block itself.
`default_nettype none

module macd_indicator_stream_test;
	timeunit 1ns;
	timeprecision 1ps;
	import macd_pkg::*;

	typedef struct {
		logic [PRICE_W-1:0] price;
		logic               restart;
	} price_item_t;

	typedef struct {
		logic [OUT_W-1:0] macd;
		logic [OUT_W-1:0] signal;
		logic [OUT_W-1:0] hist;
	} macd_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	macd_price_if price_ch ();
	macd_result_if result_ch ();

	macd_indicator_stream u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.price_ch (price_ch),
		.result_ch(result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [NUM_W-1:0] mean_num [MEANS];
	logic [DEN_W-1:0] mean_den [MEANS];
	logic [DEC_W-1:0] mean_dec [MEANS];

	price_item_t pending_prices [$];
	macd_item_t  expected_items [$];
	int  errors = 0;
	int  checked = 0;
	int  idle_cycles = 0;
	bit  quiet = 1'b0;
	bit  hold_send = 1'b0;
	int  send_gap = 0;
	int  take_gap = 0;

	function automatic logic [DEC_W-1:0] span_decay(logic [SPAN_W-1:0] span);
		logic [63:0] s;
		s = (span == 0) ? 64'd1 : 64'(span);
		return DEC_W'(((s - 1) << 32) / (s + 1));
	endfunction

	function automatic logic [63:0] scale_u(logic [63:0] a, logic [DEC_W-1:0] d);
		logic [127:0] p;
		p = 128'(a) * 128'(d);
		return p[95:32];
	endfunction

	function automatic logic [63:0] scale_s(logic [63:0] v, logic [DEC_W-1:0] d);
		logic [63:0] a;
		a = v[63] ? -v : v;
		a = scale_u(a, d);
		return v[63] ? -a : a;
	endfunction

	function automatic logic [63:0] quotient_q16(logic [63:0] n, logic [63:0] den);
		logic [63:0] a;
		logic [127:0] q;
		if (den == 0) return 64'd0;
		a = n[63] ? -n : n;
		q = {a, 32'd0} / 128'(den);
		return n[63] ? -q[63:0] : q[63:0];
	endfunction

	function automatic logic [63:0] clamp40(logic signed [64:0] v);
		if (v > 65'sd549755813887) return 64'd549755813887;
		if (v < -65'sd549755813888) return -64'd549755813888;
		return v[63:0];
	endfunction

	function automatic logic [63:0] mean_step(int k, logic [63:0] v);
		mean_num[k] = v + scale_s(mean_num[k], mean_dec[k]);
		mean_den[k] = DEN_W'(64'(ONE_Q32) + scale_u(64'(mean_den[k]), mean_dec[k]));
		return quotient_q16(mean_num[k], 64'(mean_den[k]));
	endfunction

	task automatic predict_macd(price_item_t it);
		logic [63:0] f, s, m, g, h;
		macd_item_t e;
		if (it.restart) begin
			for (int k = 0; k < MEANS; k++) begin
				mean_num[k] = '0;
				mean_den[k] = '0;
			end
		end
		f = mean_step(CFG_FAST, 64'(it.price));
		s = mean_step(CFG_SLOW, 64'(it.price));
		m = clamp40($signed({f[63], f}) - $signed({s[63], s}));
		g = mean_step(CFG_SIGNAL, m);
		g = clamp40($signed({g[63], g}));
		h = clamp40($signed({m[63], m}) - $signed({g[63], g}));
		e.macd = m[OUT_W-1:0];
		e.signal = g[OUT_W-1:0];
		e.hist = h[OUT_W-1:0];
		expected_items.push_back(e);
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			price_ch.valid <= 1'b0;
			price_ch.close_price <= '0;
			price_ch.restart <= 1'b0;
			send_gap <= 0;
		end else if (price_ch.valid && !price_ch.ready) begin
			// hold the item until taken
		end else begin
			if (price_ch.valid) begin
				predict_macd('{price_ch.close_price, price_ch.restart});
			end
			if (send_gap > 0) begin
				price_ch.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!hold_send && pending_prices.size() > 0) begin
				price_ch.valid <= 1'b1;
				price_ch.close_price <= pending_prices[0].price;
				price_ch.restart <= pending_prices[0].restart;
				void'(pending_prices.pop_front());
				if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
			end else begin
				price_ch.valid <= 1'b0;
			end
		end
	end

	// monitor and sink
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			take_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_items.size() == 0) begin
					$error("unexpected item macd=%0d", result_ch.macd_value);
					errors++;
				end else begin
					macd_item_t e;
					e = expected_items.pop_front();
					if (result_ch.macd_value !== e.macd) begin
						$error("macd_value expected %0d got %0d", $signed(e.macd),
							result_ch.macd_value);
						errors++;
					end
					if (result_ch.signal_value !== e.signal) begin
						$error("signal_value expected %0d got %0d", $signed(e.signal),
							result_ch.signal_value);
						errors++;
					end
					if (result_ch.histogram !== e.hist) begin
						$error("histogram expected %0d got %0d", $signed(e.hist),
							result_ch.histogram);
						errors++;
					end
					checked++;
				end
			end
			if ((result_ch.valid && result_ch.ready) || (price_ch.valid && price_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (take_gap > 0) begin
				result_ch.ready <= 1'b0;
				take_gap <= take_gap - 1;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				result_ch.ready <= 1'b0;
				take_gap <= $urandom_range(0, 6);
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	// stall timeout: reports a mismatch and stops once neither channel has moved an item past the idle limit
	always @(posedge clk) begin
		if (idle_cycles > 5000) begin
			$display("macd_indicator_stream: mismatch");
			$finish;
		end
	end

	function automatic logic [PRICE_W-1:0] rand_price();
		case ($urandom_range(0, 5))
			0: return $urandom();
			1: return PRICE_W'($urandom_range(0, 255)) << 16;
			2: return '1 - PRICE_W'($urandom_range(0, 3));
			3: return PRICE_W'($urandom_range(0, 15));
			default: return (PRICE_W'($urandom_range(90, 110)) << 16)
				| PRICE_W'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic queue_price(logic [PRICE_W-1:0] p, logic r);
		price_item_t it;
		it.price = p;
		it.restart = r;
		pending_prices.push_back(it);
	endtask

	task automatic drain();
		while (pending_prices.size() > 0 || price_ch.valid || expected_items.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_span(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] span);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= span;
		if (idx == CFG_FAST || idx == CFG_SLOW || idx == CFG_SIGNAL)
			mean_dec[idx] = span_decay(span);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] spans [6][3];
		spans = '{'{10'd12, 10'd26, 10'd9}, '{10'd1, 10'd1, 10'd1},
			'{10'd1023, 10'd1023, 10'd1023}, '{10'd0, 10'd1023, 10'd2},
			'{10'd3, 10'd700, 10'd0}, '{10'd12, 10'd26, 10'd9}};
		for (int k = 0; k < MEANS; k++) begin
			mean_num[k] = '0;
			mean_den[k] = '0;
		end
		mean_dec[CFG_FAST] = FAST_DEC_RST;
		mean_dec[CFG_SLOW] = SLOW_DEC_RST;
		mean_dec[CFG_SIGNAL] = SIGNAL_DEC_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, restart, saturation swings
		queue_price('0, 1'b0);
		queue_price('1, 1'b0);
		queue_price('0, 1'b0);
		queue_price('1, 1'b1);
		queue_price(32'h0001_0000, 1'b0);
		queue_price(32'h5555_5555, 1'b0);
		queue_price(32'hAAAA_AAAA, 1'b1);
		queue_price('1, 1'b0);
		queue_price('0, 1'b0);
		queue_price(32'h8000_0000, 1'b0);
		drain();

		// every register and extreme spans, written before each series; index 3 ignored
		for (int ph = 1; ph < 6; ph++) begin
			write_span(CFG_FAST, spans[ph][0]);
			write_span(CFG_SLOW, spans[ph][1]);
			write_span(CFG_SIGNAL, spans[ph][2]);
			write_span(2'd3, CFG_DATA_W'($urandom()));
			if (ph == 2) queue_price('1, 1'b0);
			for (int i = 0; i < 150; i++) begin
				logic r;
				r = (i == 0) || ($urandom_range(0, 40) == 0);
				queue_price(rand_price(), r);
				if (ph == 4 && i == 60) begin
					// pause the sender until every result is back
					while (pending_prices.size() > 0 || price_ch.valid) @(posedge clk);
					hold_send = 1'b1;
					while (expected_items.size() > 0) @(posedge clk);
					hold_send = 1'b0;
				end
			end
			drain();
		end

		// tail with no idling on either side
		quiet = 1'b1;
		write_span(CFG_FAST, CFG_DATA_W'($urandom_range(1, 1023)));
		for (int i = 0; i < 180; i++) queue_price(rand_price(), i == 0);
		drain();

		$display("Checked %0d indicator items over six span settings, restarts and extremes.",
			checked);
		if (errors == 0) begin
			$display("macd_indicator_stream: match");
		end else begin
			$display("macd_indicator_stream: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
